// ===== hdl/hash_key_count_aggregator_unit_assert.svh =====
// Assertion macros for the hash key count aggregator.
`ifndef HASH_KEY_COUNT_AGGREGATOR_UNIT_ASSERT_SVH
`define HASH_KEY_COUNT_AGGREGATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising edge of clk outside reset.
`define HKCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every rising edge of clk, reset included.
`define HKCA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HKCA_ASSERT(label, prop, msg)
`define HKCA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hdl/hkca_pkg.sv =====
// ---------------------------------------------------------------------------
// hkca_pkg
// Types, constants and helper functions of the hash key count aggregator.
// ---------------------------------------------------------------------------
package hkca_pkg;

    localparam int SLOTS         = 256;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int LEN_W         = 5;
    localparam int COUNT_W       = 48;
    localparam int INC_W         = 32;
    localparam int LIMIT_W       = 9;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    // The FNV prime is 2^40 + 435.
    localparam logic [63:0] FNV_LOW   = 64'd435;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd192;

    // Result status codes.
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [31:0] increment;
        logic [7:0]  slot_select;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [47:0] count;
        logic [4:0]  key_length;
        logic [7:0]  out_byte;
        logic        out_last;
    } out_t;

    typedef struct packed {
        logic [63:0]                  hash;
        logic [MAX_KEY_BYTES*8-1:0]   key;
        logic [LEN_W-1:0]             len;
        logic [COUNT_W-1:0]           count;
    } entry_t;

    // One FNV-1a step: xor the byte in, then multiply by the prime as shift and add.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x * FNV_LOW);
    endfunction

    function automatic out_t make_out(input logic [2:0] st, input logic [SLOT_W-1:0] sl,
                                      input logic [COUNT_W-1:0] cnt,
                                      input logic [LEN_W-1:0] len,
                                      input logic [7:0] b, input logic last);
        out_t o;
        o.status     = st;
        o.slot       = 8'(sl);
        o.count      = cnt;
        o.key_length = len;
        o.out_byte   = b;
        o.out_last   = last;
        return o;
    endfunction

endpackage

// ===== hdl/hash_key_count_aggregator_unit.sv =====
// A key byte that is not last gives no result. A last byte of a too-long key loads its
// result on acceptance; others go to S_PROBE, which loads the result if the home slot
// is free, else goes via S_CMP to S_ADD on a match or back to S_PROBE for the next slot.
// A used-slot read passes S_RD_WAIT; S_STREAM loads a byte per cycle while out_free.
// The single-port slot memory (one read or write per cycle) sets the probe rate.
// Reset clears the used marks in flip-flops at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
// hash_key_count_aggregator_unit
// Group-by counting table with FNV-1a hashing and a linearly probed slot memory.
// ---------------------------------------------------------------------------
`include "hash_key_count_aggregator_unit_assert.svh"

module hash_key_count_aggregator_unit
    import hkca_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_t                 in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_t                out_data,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_PROBE, S_CMP, S_ADD, S_RD_WAIT, S_STREAM
    } state_t;

    state_t                     state_reg;
    logic [LIMIT_W-1:0]         load_limit_reg;
    logic [63:0]                hash_reg;
    logic [MAX_KEY_BYTES*8-1:0] pend_key_reg;
    logic [LEN_W-1:0]           pend_len_reg;
    logic                       overlong_reg;
    logic [SLOTS-1:0]           slot_used_reg;
    logic [LIMIT_W-1:0]         entry_count_reg;
    logic [SLOT_W-1:0]          idx_reg;
    logic [SLOT_W-1:0]          probe_cnt_reg;
    logic [INC_W-1:0]           inc_reg;
    logic [KEY_IDX_W-1:0]       byte_cnt_reg;
    logic                       out_valid_reg;
    out_t                       out_reg;

    entry_t                     mem [SLOTS];
    entry_t                     rd_data_reg;

    logic                       out_free;
    logic                       out_load;
    logic                       in_acc;
    logic                       acc_key;
    logic                       overlong_now;
    logic                       key_done;
    logic                       mem_we;
    logic                       mem_re;
    logic [SLOT_W-1:0]          mem_addr;
    entry_t                     mem_wdata;
    logic                       key_match;
    logic [COUNT_W:0]           sum;
    logic [COUNT_W-1:0]         new_count;
    logic [7:0]                 rd_byte;
    logic                       cur_used;
    logic                       sel_used;
    logic [63:0]                next_hash;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_acc    = in_valid && in_ready;
    assign acc_key   = in_acc && !in_data.mode;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Hash after absorbing the byte on the input.
    assign next_hash = fnv_step(hash_reg, in_data.key_byte);

    // The key is too long if it already overflowed or this byte does not fit.
    assign overlong_now = overlong_reg || (pend_len_reg == LEN_W'(MAX_KEY_BYTES));
    assign cur_used     = slot_used_reg[idx_reg];
    assign sel_used     = slot_used_reg[in_data.slot_select[SLOT_W-1:0]];

    // Masked comparison of the stored key against the pending key.
    always_comb
    begin
        key_match = (rd_data_reg.hash == hash_reg) && (rd_data_reg.len == pend_len_reg);
        for (int j = 0; j < MAX_KEY_BYTES; j++)
        begin
            if ((LEN_W'(j) < pend_len_reg) &&
                (rd_data_reg.key[j*8 +: 8] != pend_key_reg[j*8 +: 8]))
            begin
                key_match = 1'b0;
            end
        end
    end

    // Saturating count update.
    assign sum       = {1'b0, rd_data_reg.count} + {{(COUNT_W+1-INC_W){1'b0}}, inc_reg};
    assign new_count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    assign rd_byte   = rd_data_reg.key[byte_cnt_reg*8 +: 8];

    // Memory port control: one read or one write per cycle.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = idx_reg;
        mem_wdata = rd_data_reg;
        key_done  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_data.mode && sel_used)
                begin
                    mem_re   = 1'b1;
                    mem_addr = in_data.slot_select[SLOT_W-1:0];
                end
                if (acc_key && in_data.key_last && overlong_now)
                begin
                    key_done = 1'b1;
                end
            end
            S_PROBE:
            begin
                if (cur_used)
                begin
                    mem_re = 1'b1;
                end
                else if (out_free)
                begin
                    key_done = 1'b1;
                    if (entry_count_reg < load_limit_reg)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata.hash  = hash_reg;
                        mem_wdata.key   = pend_key_reg;
                        mem_wdata.len   = pend_len_reg;
                        mem_wdata.count = {{(COUNT_W-INC_W){1'b0}}, inc_reg};
                    end
                end
            end
            S_CMP:
            begin
                if (!key_match && (probe_cnt_reg == SLOT_W'(SLOTS - 1)) && out_free)
                begin
                    key_done = 1'b1;
                end
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.count = new_count;
                    key_done        = 1'b1;
                end
            end
            S_RD_WAIT, S_STREAM:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // The output register takes a new result at the end of a key, on an empty read
    // and on every streamed byte.
    assign out_load = key_done
                      || ((state_reg == S_IDLE) && in_acc && in_data.mode && !sel_used)
                      || ((state_reg == S_STREAM) && out_free);

    // Slot memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            load_limit_reg <= cfg_wdata;
        end
    end

    // Pending key: hash, bytes, length and overflow flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg     <= FNV_BASIS;
            pend_len_reg <= '0;
            overlong_reg <= 1'b0;
        end
        else if (key_done)
        begin
            hash_reg     <= FNV_BASIS;
            pend_len_reg <= '0;
            overlong_reg <= 1'b0;
        end
        else if (acc_key)
        begin
            hash_reg <= next_hash;
            if (overlong_now)
            begin
                overlong_reg <= 1'b1;
            end
            else
            begin
                pend_len_reg <= pend_len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_key && !overlong_now)
        begin
            pend_key_reg[pend_len_reg[KEY_IDX_W-1:0]*8 +: 8] <= in_data.key_byte;
        end
    end

    // Control sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slot_used_reg   <= '0;
            entry_count_reg <= '0;
            idx_reg         <= '0;
            probe_cnt_reg   <= '0;
            byte_cnt_reg    <= '0;
            inc_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_data.mode)
                    begin
                        idx_reg      <= in_data.slot_select[SLOT_W-1:0];
                        byte_cnt_reg <= '0;
                        if (sel_used)
                        begin
                            state_reg <= S_RD_WAIT;
                        end
                        else
                        begin
                            out_reg <= make_out(ST_EMPTY, in_data.slot_select[SLOT_W-1:0],
                                                '0, '0, 8'd0, 1'b1);
                        end
                    end
                    else if (acc_key && in_data.key_last)
                    begin
                        if (overlong_now)
                        begin
                            out_reg <= make_out(ST_TOO_LONG, '0, '0, '0, 8'd0, 1'b1);
                        end
                        else
                        begin
                            idx_reg       <= next_hash[SLOT_W-1:0];
                            probe_cnt_reg <= '0;
                            inc_reg       <= in_data.increment;
                            state_reg     <= S_PROBE;
                        end
                    end
                end
                S_PROBE:
                begin
                    if (cur_used)
                    begin
                        state_reg <= S_CMP;
                    end
                    else if (out_free)
                    begin
                        state_reg     <= S_IDLE;
                        if (entry_count_reg < load_limit_reg)
                        begin
                            slot_used_reg[idx_reg] <= 1'b1;
                            entry_count_reg <= entry_count_reg + LIMIT_W'(1);
                            out_reg <= make_out(ST_INSERTED, idx_reg,
                                                {{(COUNT_W-INC_W){1'b0}}, inc_reg},
                                                pend_len_reg, 8'd0, 1'b1);
                        end
                        else
                        begin
                            out_reg <= make_out(ST_FULL, '0, '0, '0, 8'd0, 1'b1);
                        end
                    end
                end
                S_CMP:
                begin
                    if (key_match)
                    begin
                        state_reg <= S_ADD;
                    end
                    else if (probe_cnt_reg != SLOT_W'(SLOTS - 1))
                    begin
                        idx_reg       <= idx_reg + SLOT_W'(1);
                        probe_cnt_reg <= probe_cnt_reg + SLOT_W'(1);
                        state_reg     <= S_PROBE;
                    end
                    else if (out_free)
                    begin
                        out_reg       <= make_out(ST_FULL, '0, '0, '0, 8'd0, 1'b1);
                        state_reg     <= S_IDLE;
                    end
                end
                S_ADD:
                begin
                    if (out_free)
                    begin
                        out_reg <= make_out(ST_UPDATED, idx_reg, new_count,
                                            rd_data_reg.len, 8'd0, 1'b1);
                        state_reg <= S_IDLE;
                    end
                end
                S_RD_WAIT:
                begin
                    state_reg <= S_STREAM;
                end
                S_STREAM:
                begin
                    if (out_free)
                    begin
                        if (rd_data_reg.len == '0)
                        begin
                            out_reg <= make_out(ST_READ, idx_reg, rd_data_reg.count,
                                                rd_data_reg.len, 8'd0, 1'b1);
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            out_reg <= make_out(ST_READ, idx_reg, rd_data_reg.count,
                                                rd_data_reg.len, rd_byte,
                                                LEN_W'(byte_cnt_reg) + LEN_W'(1)
                                                == rd_data_reg.len);
                            byte_cnt_reg <= byte_cnt_reg + KEY_IDX_W'(1);
                            if (LEN_W'(byte_cnt_reg) + LEN_W'(1) == rd_data_reg.len)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks.
    `HKCA_ASSERT(a_count_matches_marks,
        entry_count_reg == LIMIT_W'($countones(slot_used_reg)),
        "entry count differs from the number of used slots")
    `HKCA_ASSERT(a_write_states,
        mem_we |-> (state_reg == S_PROBE || state_reg == S_ADD),
        "slot memory written outside probe or update")
    `HKCA_ASSERT(a_busy_after_last,
        (acc_key && in_data.key_last && !overlong_now) |=> !in_ready,
        "input taken while a key is being placed")
    `HKCA_ASSERT_ALWAYS(a_pending_bound,
        pend_len_reg <= LEN_W'(MAX_KEY_BYTES),
        "pending key length beyond the maximum")

endmodule
